@@ src/sample_word_byte_packer_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sample word byte packer
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef SAMPLE_WORD_BYTE_PACKER_CORE_ASSERT_SVH
`define SAMPLE_WORD_BYTE_PACKER_CORE_ASSERT_SVH

// Checks an implication property on every clock edge outside reset.
`define SWBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks a plain condition on every clock edge outside reset.
`define SWBP_ASSERT_COND(label, cond, msg) \
  `SWBP_ASSERT(label, (cond), msg)

`endif

@@ src/swbp_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Sample word byte packer package
// Word size mode codes, widths and the register index shared by the packer logic.
// ---------------------------------------------------------------------------
package swbp_pkg;

  localparam logic [1:0] MODE_8BIT  = 2'd0;
  localparam logic [1:0] MODE_12BIT = 2'd1;
  localparam logic [1:0] MODE_16BIT = 2'd2;

  localparam int unsigned WORD12_W = 12;
  localparam int unsigned MAX_BYTES = 3;

  // Register index of the word size mode register.
  localparam logic [1:0] REG_WORD_SIZE_MODE = 2'd0;

endpackage
`default_nettype wire

@@ src/sample_word_byte_packer_core.sv @@
// An accepted request's bytes are loaded into the byte buffer, then pass through the output register.
// One byte leaves per cycle while the receiver does not stall, so a request gives one byte in 8-bit mode
// and two in 16-bit mode. In 12-bit mode the first half of a pair gives none and the second gives three; the cycle
// that accepts the second half finds the buffer empty and leaves a gap in the byte stream.
// The byte buffer drains into the output register; a new request enters as the last byte moves.
// Reset clears the mode register (8-bit), the pending half pair, the byte count and out_valid_o.
`default_nettype none
// ---------------------------------------------------------------------------
// Sample word byte packer core
// Turns converter samples into little-endian bytes in 8-, 12- or 16-bit mode.
// ---------------------------------------------------------------------------
module sample_word_byte_packer_core
  import swbp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Sample input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] sample_i,
  input  wire logic        is_blank_i,
  input  wire logic        run_start_i,
  // Byte output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_byte_o,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [1:0]          mode_q;
  logic                pend_q, pend_d;
  logic [WORD12_W-1:0] held_q, held_d;
  logic [7:0]          pend_bytes_q [MAX_BYTES];
  logic [1:0]          cnt_q;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_last_q;

  logic                cfg_wr;
  logic                out_free;
  logic                in_accept;
  logic                pend_cur;
  logic [WORD12_W-1:0] held_cur;
  logic [15:0]         smp;
  logic [23:0]         packed_pair;
  logic [7:0]          nb [MAX_BYTES];
  logic [1:0]          ncnt;
  logic                pair_req;
  logic                word16_req;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_WORD_SIZE_MODE) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_8BIT;
    end else if (cfg_wr && paddr == REG_WORD_SIZE_MODE) begin
      mode_q <= pwdata[1:0];
    end
  end

  // Handshake control.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((cnt_q == 2'd0) || (cnt_q == 2'd1 && out_free));
  assign in_accept  = in_valid_i && !in_stall_o;

  // Byte formation for one request.
  always_comb begin
    smp         = is_blank_i ? 16'd0 : sample_i;
    pend_cur    = run_start_i ? 1'b0 : pend_q;
    held_cur    = run_start_i ? '0 : held_q;
    pend_d      = pend_cur;
    held_d      = held_cur;
    packed_pair = {smp[WORD12_W-1:0], held_cur};
    nb[0]       = smp[11:4];
    nb[1]       = 8'd0;
    nb[2]       = 8'd0;
    ncnt        = 2'd1;
    case (mode_q)
      MODE_16BIT: begin
        nb[0] = smp[7:0];
        nb[1] = smp[15:8];
        ncnt  = 2'd2;
      end
      MODE_12BIT: begin
        if (!pend_cur) begin
          pend_d = 1'b1;
          held_d = smp[WORD12_W-1:0];
          ncnt   = 2'd0;
        end else begin
          pend_d = 1'b0;
          held_d = '0;
          nb[0]  = packed_pair[7:0];
          nb[1]  = packed_pair[15:8];
          nb[2]  = packed_pair[23:16];
          ncnt   = 2'd3;
        end
      end
      default: begin
        nb[0] = smp[11:4];
        ncnt  = 2'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      held_q <= '0;
    end else if (in_accept) begin
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

  // Byte buffer: entry 0 is the next byte to leave.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (in_accept) begin
      cnt_q <= ncnt;
    end else if (out_free && cnt_q != 2'd0) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_bytes_q[0] <= nb[0];
      pend_bytes_q[1] <= nb[1];
      pend_bytes_q[2] <= nb[2];
    end else if (out_free && cnt_q != 2'd0) begin
      pend_bytes_q[0] <= pend_bytes_q[1];
      pend_bytes_q[1] <= pend_bytes_q[2];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= (cnt_q != 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && cnt_q != 2'd0) begin
      out_byte_q <= pend_bytes_q[0];
      out_last_q <= (cnt_q == 2'd1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

  assign pair_req   = in_accept && mode_q == MODE_12BIT && pend_q && !run_start_i;
  assign word16_req = in_accept && mode_q == MODE_16BIT && !run_start_i;

`include "sample_word_byte_packer_core_assert.svh"

  // A byte that is not the last of its request must have followers buffered.
  `SWBP_ASSERT_COND(a_more_bytes, !out_valid_q || out_last_q || cnt_q != 2'd0, "bytes missing")
  // The held half pair is cleared whenever no pair is pending.
  `SWBP_ASSERT_COND(a_held_clear, pend_q || held_q == '0, "held word set without pending pair")
  // Completing a 12-bit pair loads three bytes.
  `SWBP_ASSERT(a_pair_bytes, pair_req |=> cnt_q == 2'd3 && !pend_q, "pair not loaded")
  // A 16-bit request loads two bytes and leaves the pair state alone.
  `SWBP_ASSERT(a_word16_bytes, word16_req |=> cnt_q == 2'd2 && $stable(pend_q), "bad 16-bit load")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// Sample word byte packer testbench
// Sends converter samples in every word size mode. Each accepted request
// updates an in-bench packer model, and the expected bytes are queued.
// Every byte the block emits is compared with the oldest queued one. Both
// channels idle at random, and the mode register is changed between phases.
// ---------------------------------------------------------------------------
module tb_top
  import swbp_pkg::*;
();

  // Mode value with no defined format; the block treats it as 8-bit mode.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 45;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } byte_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] sample_i;
  logic        is_blank_i;
  logic        run_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Model state of the packer and its mode register.
  logic [1:0]  cfg_mode;
  logic        half_pending;
  logic [11:0] half_word;
  byte_result_t expected_bytes[$];

  bit tx_idle_en;
  bit rx_idle_en;
  int rx_wait;
  int err_count;
  int cycle_count;
  int samples_sent;
  int bytes_checked;
  int mode_writes;

  sample_word_byte_packer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .is_blank_i  (is_blank_i),
    .run_start_i (run_start_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void push_byte(input logic [7:0] b, input logic last);
    expected_bytes.push_back('{out_byte: b, last_byte: last});
  endfunction

  // Serializes one sample the way the block should, in the current mode.
  function automatic void pack_sample(input logic [15:0] smp, input logic blank,
                                      input logic start);
    logic [15:0] s;
    logic [23:0] pair;
    s = blank ? 16'h0000 : smp;
    if (start) begin
      half_pending = 1'b0;
      half_word = '0;
    end
    case (cfg_mode)
      MODE_16BIT: begin
        push_byte(s[7:0], 1'b0);
        push_byte(s[15:8], 1'b1);
      end
      MODE_12BIT: begin
        if (!half_pending) begin
          half_word = s[11:0];
          half_pending = 1'b1;
        end else begin
          pair = {s[11:0], half_word};
          push_byte(pair[7:0], 1'b0);
          push_byte(pair[15:8], 1'b0);
          push_byte(pair[23:16], 1'b1);
          half_word = '0;
          half_pending = 1'b0;
        end
      end
      default: begin
        push_byte(s[11:4], 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin : monitor
    byte_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pack_sample(sample_i, is_blank_i, run_start_i);
        samples_sent++;
      end
      if (out_valid_o && !out_stall_i) begin
        rx_wait = rx_idle_en ? $urandom_range(0, 16) : 0;
        bytes_checked++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte %02h (last_byte %0b)", out_byte_o, last_byte_o);
          err_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_o !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, out_byte_o);
            err_count++;
          end
          if (last_byte_o !== want.last_byte) begin
            $error("last_byte: expected %0b, actual %0b", want.last_byte, last_byte_o);
            err_count++;
          end
        end
      end
    end
  end

  // Byte receiver: after each accepted byte it stalls for the drawn count.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_sample(input logic [15:0] smp, input logic blank,
                             input logic start);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 16) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    sample_i    <= smp;
    is_blank_i  <= blank;
    run_start_i <= start;
    @(posedge clk_i);
    while (!(in_valid_i && !in_stall_o)) @(posedge clk_i);
  endtask

  task automatic send_random_sample();
    send_sample(16'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
  endtask

  // Lowers the request line and waits until every expected byte has left,
  // then waits DRAIN_CYCLES more for a half pair that produced no byte.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    wait_idle();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(4 * int'(REG_WORD_SIZE_MODE));
    pwdata  <= 32'(mode);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cfg_mode = mode;
    mode_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(mode)) begin
      $error("prdata: expected %08h, actual %08h", 32'(mode), prdata);
      err_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The mode register comes out of reset in 8-bit mode.
  task automatic test_default_mode();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_sample(16'h0000, 1'b0, 1'b1);
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'h0FF0, 1'b0, 1'b0);
    send_sample(16'hF00F, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
  endtask

  task automatic test_word16();
    write_mode(MODE_16BIT);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'h0000, 1'b0, 1'b1);
    send_sample(16'h8001, 1'b0, 1'b0);
    send_sample(16'hBEEF, 1'b1, 1'b0);
  endtask

  task automatic test_word12_pairs();
    write_mode(MODE_12BIT);
    send_sample(16'hFFFF, 1'b0, 1'b1);
    send_sample(16'h0000, 1'b0, 1'b0);
    // Blank padding with nonzero sample bits, then a new run for the data.
    send_sample(16'hFFFF, 1'b1, 1'b1);
    send_sample(16'h5A5A, 1'b1, 1'b0);
    send_sample(16'hF123, 1'b0, 1'b1);
    send_sample(16'h0ABC, 1'b0, 1'b0);
    // A run start throws away the unpaired first half.
    send_sample(16'h0111, 1'b0, 1'b0);
    send_sample(16'h0222, 1'b0, 1'b1);
    send_sample(16'h0333, 1'b0, 1'b0);
    // A half pair stays pending across a visit to 16-bit mode.
    send_sample(16'h0777, 1'b0, 1'b0);
    write_mode(MODE_16BIT);
    send_sample(16'h4321, 1'b0, 1'b0);
    write_mode(MODE_12BIT);
    send_sample(16'h0888, 1'b0, 1'b0);
  endtask

  task automatic test_unused_mode();
    write_mode(MODE_UNUSED);
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'h0010, 1'b0, 1'b1);
    send_sample(16'hFFFF, 1'b1, 1'b0);
  endtask

  task automatic test_random_runs();
    logic [1:0] phase_modes[8];
    int sent;
    int pad;
    int len;
    phase_modes = '{MODE_8BIT, MODE_12BIT, MODE_16BIT, MODE_UNUSED,
                    MODE_12BIT, MODE_16BIT, MODE_12BIT, MODE_8BIT};
    for (int p = 0; p < 8; p++) begin
      write_mode(phase_modes[p]);
      tx_idle_en = (p % 3) != 0;
      rx_idle_en = (p % 4) != 1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (cfg_mode == MODE_12BIT && $urandom_range(0, 7) != 0) begin
          // Padding run followed by a data run, each opened by a run start.
          pad = $urandom_range(0, 3);
          len = $urandom_range(1, 12);
          for (int i = 0; i < pad; i++) send_sample(16'($urandom), 1'b1, i == 0);
          for (int i = 0; i < len; i++) begin
            send_sample(16'($urandom), $urandom_range(0, 15) == 0, i == 0);
          end
          sent += pad + len;
        end else begin
          send_random_sample();
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    is_blank_i  = 1'b0;
    run_start_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cfg_mode     = MODE_8BIT;
    half_pending = 1'b0;
    half_word    = '0;
    tx_idle_en   = 1'b0;
    rx_idle_en   = 1'b0;
    rx_wait      = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_mode();
    test_word16();
    test_word12_pairs();
    test_unused_mode();
    test_random_runs();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples and checked %0d bytes over %0d mode register writes.",
             samples_sent, bytes_checked, mode_writes);
    $display("Modes 8, 12 and 16 bit and the unused code ran with random idles on both sides.");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
